// ===== sv/integer_to_text_formatter_defines.svh =====
// Assertion macros shared by the integer_to_text_formatter RTL.
// No dependencies; include before any module that asserts.
`ifndef INTEGER_TO_TEXT_FORMATTER_DEFINES_SVH
`define INTEGER_TO_TEXT_FORMATTER_DEFINES_SVH
`ifndef SYNTHESIS
`define ITF_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ITF_ASSERT(lbl, prop, msg) `ITF_ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)
`else
`define ITF_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ITF_ASSERT(lbl, prop, msg)
`endif
`endif

// ===== sv/itf_pkg.sv =====
// Package for the integer-to-text formatter: defaults, character codes,
// sequencer states and the control/status words between sequencer and digit unit.
package itf_pkg;

    localparam int BUF_MAX_DEF    = 64;
    localparam int VALUE_BITS_DEF = 64;

    localparam logic [7:0] CH_ZERO    = 8'h30;  // '0'
    localparam logic [7:0] CH_MINUS   = 8'h2d;  // '-'
    localparam logic [7:0] CH_HEX_OFS = 8'h57;  // 'a' - 10
    localparam logic [7:0] CH_NUL     = 8'h00;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_NORM,
        S_LEN,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        DOP_HOLD,
        DOP_LOAD,
        DOP_DABBLE,
        DOP_SHIFT
    } t_dop;

    typedef struct packed {
        t_dop op;
        logic neg;
        logic hex;
    } t_dcmd;

    typedef struct packed {
        logic [3:0] top;
        logic       top_zero;
    } t_dstat;

endpackage

// ===== sv/itf_digit_unit.sv =====
// Digit datapath: magnitude register and a shared shift / add-3 unit that
// builds BCD or hex nibbles and shifts them out top first. Uses itf_pkg.
module itf_digit_unit #(
    parameter int VALUE_BITS = itf_pkg::VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic [VALUE_BITS-1:0] i_value,
    input  itf_pkg::t_dcmd        i_dcmd,
    output itf_pkg::t_dstat       o_dstat
);
    import itf_pkg::*;

    localparam int ND = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int DW = ND * 4;

    logic [VALUE_BITS-1:0] r_bin, n_bin;
    logic [DW-1:0]         r_dig, n_dig;
    logic [VALUE_BITS-1:0] mag;
    logic [DW-1:0]         adj;

    assign mag = i_dcmd.neg ? (~i_value + 1'b1) : i_value;

    // add 3 to every BCD digit of 5 or more before the shift
    always_comb begin
        for (int k = 0; k < ND; k++) begin
            adj[k*4 +: 4] = (r_dig[k*4 +: 4] >= 4'd5) ? r_dig[k*4 +: 4] + 4'd3
                                                      : r_dig[k*4 +: 4];
        end
    end

    always_comb begin
        n_bin = r_bin;
        n_dig = r_dig;
        unique case (i_dcmd.op)
            DOP_HOLD: ;
            DOP_LOAD: begin
                n_bin = mag;
                n_dig = i_dcmd.hex ? DW'(mag) : '0;
            end
            DOP_DABBLE: begin
                n_dig = {adj[DW-2:0], r_bin[VALUE_BITS-1]};
                n_bin = {r_bin[VALUE_BITS-2:0], 1'b0};
            end
            DOP_SHIFT: n_dig = {r_dig[DW-5:0], 4'd0};
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_bin <= n_bin;
        r_dig <= n_dig;
    end

    assign o_dstat.top      = r_dig[DW-1 -: 4];
    assign o_dstat.top_zero = (r_dig[DW-1 -: 4] == 4'd0);

endmodule

// ===== sv/itf_ctrl.sv =====
// Sequencer: captures the command, steps the digit unit, works out lengths
// and emits one text byte per cycle. Uses itf_pkg and the assertion macros.
`include "integer_to_text_formatter_defines.svh"
module itf_ctrl #(
    parameter int BUF_MAX    = itf_pkg::BUF_MAX_DEF,
    parameter int VALUE_BITS = itf_pkg::VALUE_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  logic            i_msb,
    input  logic            i_is_signed,
    input  logic            i_base_hex,
    input  logic [7:0]      i_min_width,
    input  logic [6:0]      i_buf_size,
    input  itf_pkg::t_dstat i_dstat,
    output itf_pkg::t_dcmd  o_dcmd,
    output logic            busy,
    output logic            o_valid,
    output logic [7:0]      o_out_char,
    output logic            o_char_valid,
    output logic            o_is_last,
    output logic [8:0]      o_full_length
);
    import itf_pkg::*;

    localparam int ND  = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int NDW = $clog2(ND + 1);
    localparam int CW  = $clog2(VALUE_BITS);
    localparam logic [10:0] BUF_MAX_L = 11'(BUF_MAX);

    t_state r_state, n_state;

    logic           r_neg, r_empty;
    logic [7:0]     r_minw;
    logic [6:0]     r_bsize, r_count, r_i;
    logic [CW-1:0]  r_cnt;
    logic [NDW-1:0] r_nd;
    logic [8:0]     r_full, r_pad_end;

    logic           r_valid, r_cvalid, r_last;
    logic [7:0]     r_char;
    logic [8:0]     r_ofull;

    // command capture and length math
    logic [6:0] bsize_c;
    logic [8:0] s9, width9, n9, zeros9, full9, frep9, bm1;
    logic       emit_done;

    // emit-side selection
    logic [8:0] i9;
    logic [7:0] dig_ch, e_char;
    logic       e_cvalid, e_last, e_digit;

    assign bsize_c = ({4'd0, i_buf_size} > BUF_MAX_L) ? 7'(BUF_MAX) : i_buf_size;

    assign s9     = {8'd0, r_neg};
    assign width9 = ({1'b0, r_minw} > s9) ? {1'b0, r_minw} - s9 : 9'd0;
    assign n9     = 9'(r_nd);
    assign zeros9 = (width9 > n9) ? width9 - n9 : 9'd0;
    assign full9  = s9 + zeros9 + n9;
    assign frep9  = (r_neg && r_bsize < 7'd2) ? 9'd0 : full9;
    assign bm1    = {2'd0, r_bsize} - 9'd1;

    assign i9     = {2'd0, r_i};
    assign dig_ch = (i_dstat.top >= 4'd10) ? CH_HEX_OFS + {4'd0, i_dstat.top}
                                           : CH_ZERO + {4'd0, i_dstat.top};
    assign emit_done = r_empty || (r_i == r_count);

    always_comb begin
        e_char   = CH_NUL;
        e_cvalid = 1'b1;
        e_last   = 1'b0;
        e_digit  = 1'b0;
        priority if (r_empty) begin
            e_cvalid = 1'b0;
            e_last   = 1'b1;
        end else if (r_i == r_count) begin
            e_last = 1'b1;
        end else if (i9 < s9) begin
            e_char = CH_MINUS;
        end else if (i9 < r_pad_end) begin
            e_char = CH_ZERO;
        end else begin
            e_char  = dig_ch;
            e_digit = 1'b1;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (start) n_state = i_base_hex ? S_NORM : S_CONV;
            S_CONV: if (r_cnt == '0) n_state = S_NORM;
            S_NORM: if (!(i_dstat.top_zero && r_nd > NDW'(1))) n_state = S_LEN;
            S_LEN:  n_state = S_EMIT;
            S_EMIT: if (emit_done) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs to the digit unit
    always_comb begin
        o_dcmd.op  = DOP_HOLD;
        o_dcmd.neg = i_is_signed & i_msb;
        o_dcmd.hex = i_base_hex;
        unique case (r_state)
            S_IDLE: if (start) o_dcmd.op = DOP_LOAD;
            S_CONV: o_dcmd.op = DOP_DABBLE;
            S_NORM: if (i_dstat.top_zero && r_nd > NDW'(1)) o_dcmd.op = DOP_SHIFT;
            S_LEN:  ;
            S_EMIT: if (e_digit) o_dcmd.op = DOP_SHIFT;
            default: ;
        endcase
    end

    assign busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == S_EMIT);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    r_neg   <= i_is_signed & i_msb;
                    r_minw  <= i_min_width;
                    r_bsize <= bsize_c;
                    r_cnt   <= CW'(VALUE_BITS - 1);
                    r_nd    <= NDW'(ND);
                end
            end
            S_CONV: r_cnt <= r_cnt - 1'b1;
            S_NORM: if (i_dstat.top_zero && r_nd > NDW'(1)) r_nd <= r_nd - 1'b1;
            S_LEN: begin
                r_full    <= frep9;
                r_pad_end <= s9 + zeros9;
                r_empty   <= (r_bsize == 7'd0);
                r_count   <= (r_bsize == 7'd0) ? 7'd0
                           : (frep9 < bm1) ? frep9[6:0] : bm1[6:0];
                r_i       <= 7'd0;
            end
            S_EMIT: r_i <= r_i + 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_char   <= e_char;
        r_cvalid <= e_cvalid;
        r_last   <= e_last;
        r_ofull  <= r_full;
    end

    assign o_valid       = r_valid;
    assign o_out_char    = r_char;
    assign o_char_valid  = r_cvalid;
    assign o_is_last     = r_last;
    assign o_full_length = r_ofull;

    `ITF_ASSERT(a_gap_after_last, o_valid && o_is_last |=> !o_valid, "word right after last")
    `ITF_ASSERT(a_invalid_is_last, o_valid && !o_char_valid |-> o_is_last, "empty word not last")
    `ITF_ASSERT(a_emit_in_range, r_state == S_EMIT && !r_empty |-> r_i <= r_count, "index past count")
    `ITF_ASSERT(a_digits_nonzero, r_state == S_NORM || r_state == S_LEN |-> r_nd != '0, "no digits")
    `ITF_ASSERT(a_busy_when_valid, o_valid && !o_is_last |-> busy, "idle mid text")

endmodule

// ===== sv/integer_to_text_formatter.sv =====
// Top level of the integer-to-text formatter: sequencer plus digit unit.
// Depends on itf_pkg, itf_ctrl and itf_digit_unit.
//
//  channel | direction | handshake                | words
//  --------+-----------+--------------------------+----------------------------------
//  command | in        | start high, busy low     | value, sign, base, width, buffer
//  text    | out       | o_valid, no stall        | char, char_valid, last, full length
//
// Steps per command: a load, VALUE_BITS shift/add-3 steps for decimal (none for
// hex), up to ND-1 leading-zero shifts plus a check that finds the top digit, a length
// step, then one output word per cycle: count+1 words, count <= min(buf_size,BUF_MAX)-1.
// The single shared digit register and its shift/add-3 unit set this sequence.
// Reset is synchronous and returns the sequencer to idle; no clearing pass.
// The receiver cannot stall: each word is shown for exactly one cycle.
module integer_to_text_formatter #(
    parameter int BUF_MAX    = itf_pkg::BUF_MAX_DEF,
    parameter int VALUE_BITS = itf_pkg::VALUE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] i_value,
    input  logic        i_is_signed,
    input  logic        i_base_hex,
    input  logic [7:0]  i_min_width,
    input  logic [6:0]  i_buf_size,
    output logic        o_valid,
    output logic [7:0]  o_out_char,
    output logic        o_char_valid,
    output logic        o_is_last,
    output logic [8:0]  o_full_length
);
    import itf_pkg::*;

    t_dcmd  dcmd;
    t_dstat dstat;

    itf_digit_unit #(
        .VALUE_BITS(VALUE_BITS)
    ) u_digit (
        .i_clk   (i_clk),
        .i_value (i_value[VALUE_BITS-1:0]),
        .i_dcmd  (dcmd),
        .o_dstat (dstat)
    );

    itf_ctrl #(
        .BUF_MAX   (BUF_MAX),
        .VALUE_BITS(VALUE_BITS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_msb        (i_value[VALUE_BITS-1]),
        .i_is_signed  (i_is_signed),
        .i_base_hex   (i_base_hex),
        .i_min_width  (i_min_width),
        .i_buf_size   (i_buf_size),
        .i_dstat      (dstat),
        .o_dcmd       (dcmd),
        .busy         (busy),
        .o_valid      (o_valid),
        .o_out_char   (o_out_char),
        .o_char_valid (o_char_valid),
        .o_is_last    (o_is_last),
        .o_full_length(o_full_length)
    );

endmodule
